FILE: design/ps2md_pkg.sv
// Shared types and constants for the mouse packet decoder.
// No dependencies; imported by every design module but the checker.
`timescale 1ns / 1ps
`default_nettype none

package ps2md_pkg;

	localparam int unsigned DPI_W = 10;
	localparam int unsigned MAG_W = 17;   // |byte| * dpi stays below 2^17
	localparam int unsigned Q_W   = 11;   // scaled magnitude up to 1280
	localparam int unsigned MOVE_W = 12;

	localparam logic [DPI_W-1:0] DPI_MIN   = 10'd10;
	localparam logic [DPI_W-1:0] DPI_MAX   = 10'd1000;
	localparam logic [DPI_W-1:0] DPI_RESET = 10'd100;

	// floor(n / 100) == (n * RECIP_MULT) >> RECIP_SHIFT for n < 2^17
	localparam int unsigned      RECIP_SHIFT = 24;
	localparam logic [17:0]      RECIP_MULT  = 18'd167773;

	localparam int unsigned STATUS_SYNC_BIT = 3;
	localparam int unsigned EXTRA_BTN4_BIT  = 4;
	localparam int unsigned EXTRA_BTN5_BIT  = 5;

	typedef enum logic [0:0] {
		REG_DPI  = 1'b0,
		REG_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [DPI_W-1:0] dpi;
		logic             wheel_mode;
		logic             restart;    // wheel_mode written this cycle
	} cfg_t;

	typedef struct packed {
		logic             ok;
		logic [4:0]       buttons;
		logic [3:0]       wheel;
		logic             x_neg;
		logic [MAG_W-1:0] x_mag;      // |dx| * dpi
		logic             y_neg;
		logic [MAG_W-1:0] y_mag;      // |dy| * dpi
	} pkt_t;

endpackage

`default_nettype wire

FILE: design/ps2md_regs.sv
// Configuration registers behind the APB-style port: scale and packet mode.
// Depends on ps2md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2md_regs
	import ps2md_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [DPI_W-1:0] dpi_q;
	logic             wheel_mode_q;
	logic             wr;
	reg_idx_t         idx;
	logic [DPI_W-1:0] wr_dpi;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	// clamp the scale into its legal range
	always_comb begin
		wr_dpi = pwdata[DPI_W-1:0];
		if (wr_dpi < DPI_MIN) begin
			wr_dpi = DPI_MIN;
		end else if (wr_dpi > DPI_MAX) begin
			wr_dpi = DPI_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpi_q        <= DPI_RESET;
			wheel_mode_q <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_DPI:  dpi_q        <= wr_dpi;
				REG_MODE: wheel_mode_q <= pwdata[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DPI:  prdata = {{(32-DPI_W){1'b0}}, dpi_q};
			REG_MODE: prdata = {31'b0, wheel_mode_q};
			default:  prdata = 32'b0;
		endcase
	end

	assign cfg.dpi        = dpi_q;
	assign cfg.wheel_mode = wheel_mode_q;
	assign cfg.restart    = wr && (idx == REG_MODE);

endmodule

`default_nettype wire

FILE: design/ps2md_assemble.sv
// Byte gathering and packet decode: holds the leading bytes, then registers
// the decoded packet with raw scale products into stage 1. Depends on ps2md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2md_assemble
	import ps2md_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       take_s1,
	output pkt_t            pkt_s1,
	output logic            pkt_valid_s1
);

	logic [1:0]       pos_q;
	logic [7:0]       held_q [3];
	logic             last_byte;
	logic             accept;
	logic             ready_s1;
	pkt_t             pkt;
	logic [7:0]       y_raw;
	logic [7:0]       x_abs;
	logic [7:0]       y_abs;
	logic [17:0]      x_prod;
	logic [17:0]      y_prod;

	assign last_byte = (pos_q == (cfg.wheel_mode ? 2'd3 : 2'd2));
	assign ready_s1  = !pkt_valid_s1 || take_s1;
	// only the closing byte needs room in stage 1
	assign in_stall  = last_byte && !ready_s1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (cfg.restart) begin
			pos_q <= 2'd0;
		end else if (accept) begin
			pos_q <= last_byte ? 2'd0 : pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last_byte) begin
			held_q[pos_q] <= rx_byte;
		end
	end

	// decode with the closing byte still on the input
	always_comb begin
		y_raw  = cfg.wheel_mode ? held_q[2] : rx_byte;
		x_abs  = held_q[1][7] ? (~held_q[1] + 8'd1) : held_q[1];
		y_abs  = y_raw[7] ? (~y_raw + 8'd1) : y_raw;
		x_prod = {10'b0, x_abs} * {8'b0, cfg.dpi};
		y_prod = {10'b0, y_abs} * {8'b0, cfg.dpi};

		pkt.ok      = held_q[0][STATUS_SYNC_BIT];
		pkt.buttons = {cfg.wheel_mode && rx_byte[EXTRA_BTN5_BIT],
		               cfg.wheel_mode && rx_byte[EXTRA_BTN4_BIT],
		               held_q[0][2:0]};
		pkt.wheel   = cfg.wheel_mode ? rx_byte[3:0] : 4'd0;
		pkt.x_neg   = held_q[1][7];
		pkt.x_mag   = x_prod[MAG_W-1:0];
		pkt.y_neg   = y_raw[7];
		pkt.y_mag   = y_prod[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			pkt_valid_s1 <= 1'b1;
		end else if (take_s1) begin
			pkt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			pkt_s1 <= pkt;
		end
	end

endmodule

`default_nettype wire

FILE: design/ps2md_result.sv
// Result stage: divides the scale products by 100, applies signs, updates the
// running statistics and holds the result register. Depends on ps2md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2md_result
	import ps2md_pkg::*;
#(
	parameter int unsigned STAT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pkt_t        pkt_s1,
	input  wire logic        pkt_valid_s1,
	output logic             take_s1,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             packet_ok,
	output logic [4:0]       buttons,
	output logic signed [11:0] move_x,
	output logic signed [11:0] move_y,
	output logic signed [3:0]  wheel,
	output logic [31:0]      good_count,
	output logic [31:0]      bad_count,
	output logic [31:0]      click_count,
	output logic [31:0]      wheel_count,
	output logic signed [31:0] sum_x,
	output logic signed [31:0] sum_y,
	output logic [31:0]      distance
);

	logic [MAG_W+17:0]       x_recip;
	logic [MAG_W+17:0]       y_recip;
	logic [Q_W-1:0]          qx;
	logic [Q_W-1:0]          qy;
	logic [MOVE_W-1:0]       dx;
	logic [MOVE_W-1:0]       dy;
	logic [2:0]              clicks;
	logic                    load;

	logic                    out_valid_q;
	logic                    packet_ok_q;
	logic [4:0]              buttons_q;
	logic [MOVE_W-1:0]       move_x_q;
	logic [MOVE_W-1:0]       move_y_q;
	logic [3:0]              wheel_q;

	logic [STAT_WIDTH-1:0]   good_q;
	logic [STAT_WIDTH-1:0]   bad_q;
	logic [STAT_WIDTH-1:0]   click_q;
	logic [STAT_WIDTH-1:0]   wheel_cnt_q;
	logic [STAT_WIDTH-1:0]   sum_x_q;
	logic [STAT_WIDTH-1:0]   sum_y_q;
	logic [STAT_WIDTH-1:0]   dist_q;

	assign take_s1 = !out_valid_q || !out_stall;
	assign load    = pkt_valid_s1 && take_s1;

	always_comb begin
		x_recip = {18'b0, pkt_s1.x_mag} * {{MAG_W{1'b0}}, RECIP_MULT};
		y_recip = {18'b0, pkt_s1.y_mag} * {{MAG_W{1'b0}}, RECIP_MULT};
		qx      = x_recip[RECIP_SHIFT +: Q_W];
		qy      = y_recip[RECIP_SHIFT +: Q_W];
		dx      = pkt_s1.x_neg ? -{1'b0, qx} : {1'b0, qx};
		// vertical axis flips: negative raw dy becomes positive
		dy      = pkt_s1.y_neg ? {1'b0, qy} : -{1'b0, qy};
		clicks  = 3'($countones(pkt_s1.buttons));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			packet_ok_q <= pkt_s1.ok;
			buttons_q   <= pkt_s1.ok ? pkt_s1.buttons : 5'd0;
			move_x_q    <= pkt_s1.ok ? dx : '0;
			move_y_q    <= pkt_s1.ok ? dy : '0;
			wheel_q     <= pkt_s1.ok ? pkt_s1.wheel : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q      <= '0;
			bad_q       <= '0;
			click_q     <= '0;
			wheel_cnt_q <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			dist_q      <= '0;
		end else if (load) begin
			if (pkt_s1.ok) begin
				good_q  <= good_q + STAT_WIDTH'(1);
				click_q <= click_q + STAT_WIDTH'(clicks);
				if (pkt_s1.wheel != 4'd0) begin
					wheel_cnt_q <= wheel_cnt_q + STAT_WIDTH'(1);
				end
				sum_x_q <= sum_x_q + {{(STAT_WIDTH-MOVE_W){dx[MOVE_W-1]}}, dx};
				sum_y_q <= sum_y_q + {{(STAT_WIDTH-MOVE_W){dy[MOVE_W-1]}}, dy};
				dist_q  <= dist_q + STAT_WIDTH'(qx) + STAT_WIDTH'(qy);
			end else begin
				bad_q <= bad_q + STAT_WIDTH'(1);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_ok   = packet_ok_q;
	assign buttons     = buttons_q;
	assign move_x      = signed'(move_x_q);
	assign move_y      = signed'(move_y_q);
	assign wheel       = signed'(wheel_q);
	// totals only move when a result loads, so they hold with it
	assign good_count  = 32'(good_q);
	assign bad_count   = 32'(bad_q);
	assign click_count = 32'(click_q);
	assign wheel_count = 32'(wheel_cnt_q);
	assign sum_x       = signed'(32'(sum_x_q));
	assign sum_y       = signed'(32'(sum_y_q));
	assign distance    = 32'(dist_q);

endmodule

`default_nettype wire

FILE: design/ps2_mouse_packet_decoder_top.sv
// Mouse packet decoder: one byte per cycle while in_stall is low; leading bytes are
// absorbed in the cycle they transfer, the closing byte is registered into stage 1,
// then into the result register. Sustained rate one byte per cycle while out_stall is low.
// Reset: scale 100 percent, wheel packets, assembly at byte 0, all totals zero,
// no result pending.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_decoder_top
	import ps2md_pkg::*;
#(
	parameter int unsigned STAT_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    rx_byte,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               packet_ok,
	output logic [4:0]         buttons,
	output logic signed [11:0] move_x,
	output logic signed [11:0] move_y,
	output logic signed [3:0]  wheel,
	output logic [31:0]        good_count,
	output logic [31:0]        bad_count,
	output logic [31:0]        click_count,
	output logic [31:0]        wheel_count,
	output logic signed [31:0] sum_x,
	output logic signed [31:0] sum_y,
	output logic [31:0]        distance
);

	cfg_t cfg;
	pkt_t pkt_s1;
	logic pkt_valid_s1;
	logic take_s1;

	ps2md_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ps2md_assemble u_assemble (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.take_s1      (take_s1),
		.pkt_s1       (pkt_s1),
		.pkt_valid_s1 (pkt_valid_s1)
	);

	ps2md_result #(
		.STAT_WIDTH (STAT_WIDTH)
	) u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.pkt_s1       (pkt_s1),
		.pkt_valid_s1 (pkt_valid_s1),
		.take_s1      (take_s1),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packet_ok    (packet_ok),
		.buttons      (buttons),
		.move_x       (move_x),
		.move_y       (move_y),
		.wheel        (wheel),
		.good_count   (good_count),
		.bad_count    (bad_count),
		.click_count  (click_count),
		.wheel_count  (wheel_count),
		.sum_x        (sum_x),
		.sum_y        (sum_y),
		.distance     (distance)
	);

endmodule

`default_nettype wire

FILE: design/ps2md_checker.sv
// Port-level checks for the mouse packet decoder, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ps2md_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               packet_ok,
	input wire logic [4:0]         buttons,
	input wire logic signed [11:0] move_x,
	input wire logic signed [11:0] move_y,
	input wire logic signed [3:0]  wheel,
	input wire logic [31:0]        good_count
);

	// a rejected packet carries no movement, buttons or wheel
	a_bad_pkt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_ok |->
			buttons == 5'd0 && move_x == 12'sd0 && move_y == 12'sd0 && wheel == 4'sd0)
		else $error("rejected packet with nonzero payload");

	a_move_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_ok |-> move_x >= -12'sd1280 && move_x <= 12'sd1270)
		else $error("move_x out of scaled range");

	a_move_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_ok |-> move_y >= -12'sd1270 && move_y <= 12'sd1280)
		else $error("move_y out of scaled range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(good_count) && $stable(move_x))
		else $error("result changed while stalled");

endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_ps2md_checker (.*);

`default_nettype wire

FILE: tb/ps2_mouse_packet_decoder_top_test.sv
// Self-checking test of the mouse packet decoder: bytes in, decoded packets out.
// Keeps its own decoder model and compares every packet; needs ps2md_pkg and the top level.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_top_test;
	import ps2md_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic        ok;
		logic [4:0]  buttons;
		logic [11:0] move_x;
		logic [11:0] move_y;
		logic [3:0]  wheel;
		logic [31:0] good;
		logic [31:0] bad;
		logic [31:0] clicks;
		logic [31:0] wheels;
		logic [31:0] sum_x;
		logic [31:0] sum_y;
		logic [31:0] travel;
	} packet_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        packet_ok;
	logic [4:0]  buttons;
	logic signed [11:0] move_x;
	logic signed [11:0] move_y;
	logic signed [3:0]  wheel;
	logic [31:0] good_count;
	logic [31:0] bad_count;
	logic [31:0] click_count;
	logic [31:0] wheel_count;
	logic signed [31:0] sum_x;
	logic signed [31:0] sum_y;
	logic [31:0] distance;

	// decoder model state
	logic [9:0]  scale_pct = DPI_RESET;
	logic        wheel_on = 1'b1;
	logic [1:0]  asm_pos = '0;
	logic [7:0]  asm_bytes [3];
	logic [31:0] good_tot = '0;
	logic [31:0] bad_tot = '0;
	logic [31:0] click_tot = '0;
	logic [31:0] wheel_tot = '0;
	logic [31:0] x_tot = '0;
	logic [31:0] y_tot = '0;
	logic [31:0] travel_tot = '0;

	packet_report_t predicted_packets [$];

	int  mismatch_count = 0;
	int  bytes_sent = 0;
	int  packets_checked = 0;
	int  writes_done = 0;
	bit  in_gaps_on = 1'b1;
	bit  stall_on = 1'b1;
	bit  hold_request = 1'b0;
	int  stall_left = 0;
	int  quiet_cycles = 0;

	ps2_mouse_packet_decoder_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.packet_ok(packet_ok), .buttons(buttons), .move_x(move_x), .move_y(move_y),
		.wheel(wheel), .good_count(good_count), .bad_count(bad_count),
		.click_count(click_count), .wheel_count(wheel_count),
		.sum_x(sum_x), .sum_y(sum_y), .distance(distance)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int scale_delta(input logic [7:0] raw);
		int v;
		v = $signed(raw);
		return (v * int'(scale_pct)) / 100;
	endfunction

	// Advance the packet assembly by one byte; returns 1 when a packet closes.
	function automatic bit decode_mouse_byte(input logic [7:0] b, output packet_report_t rep);
		int dx;
		int dy;
		int wh;
		logic [4:0] btn;
		logic [7:0] ext;
		rep = '0;
		if (asm_pos < (wheel_on ? 2'd3 : 2'd2)) begin
			asm_bytes[asm_pos] = b;
			asm_pos++;
			return 1'b0;
		end
		asm_pos = '0;
		if (!asm_bytes[0][STATUS_SYNC_BIT]) begin
			bad_tot++;
		end else begin
			ext = wheel_on ? b : 8'h00;
			btn = {ext[EXTRA_BTN5_BIT], ext[EXTRA_BTN4_BIT], asm_bytes[0][2:0]};
			dx = scale_delta(asm_bytes[1]);
			dy = -scale_delta(wheel_on ? asm_bytes[2] : b);
			wh = $signed(ext[3:0]);
			good_tot++;
			click_tot += $countones(btn);
			if (wh != 0)
				wheel_tot++;
			x_tot += dx;
			y_tot += dy;
			travel_tot += (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
			rep.ok = 1'b1;
			rep.buttons = btn;
			rep.move_x = dx[11:0];
			rep.move_y = dy[11:0];
			rep.wheel = wh[3:0];
		end
		rep.good = good_tot;
		rep.bad = bad_tot;
		rep.clicks = click_tot;
		rep.wheels = wheel_tot;
		rep.sum_x = x_tot;
		rep.sum_y = y_tot;
		rep.travel = travel_tot;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		packet_report_t rep;
		int gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		if (decode_mouse_byte(b, rep))
			predicted_packets.push_back(rep);
		gap = pick_gap(in_gaps_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Send the first n bytes of data, most significant byte first.
	task automatic send_packet(input logic [31:0] data, input int n);
		for (int i = 0; i < n; i++)
			send_byte(data[31-8*i -: 8]);
	endtask

	task automatic send_random_packet();
		logic [31:0] data;
		data = $urandom;
		data[24+STATUS_SYNC_BIT] = ($urandom_range(0, 9) != 0);
		send_packet(data, wheel_on ? 4 : 3);
	endtask

	// Drop valid, wait for every packet, then let the pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (predicted_packets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_readback(input reg_idx_t r);
		logic [31:0] want;
		want = (r == REG_DPI) ? {22'b0, scale_pct} : {31'b0, wheel_on};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch(r == REG_DPI ? "dpi_percent readback" : "wheel_mode readback",
				prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t r, input logic [31:0] value);
		logic [9:0] v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		writes_done++;
		case (r)
			REG_DPI: begin
				v = value[9:0];
				if (v < DPI_MIN)
					v = DPI_MIN;
				else if (v > DPI_MAX)
					v = DPI_MAX;
				scale_pct = v;
			end
			REG_MODE: begin
				wheel_on = value[0];
				asm_pos = '0;
			end
		endcase
		reg_readback(r);
	endtask

	task automatic test_reset_values();
		reg_readback(REG_DPI);
		reg_readback(REG_MODE);
	endtask

	task automatic test_wheel_packets();
		// all buttons with overflow bits, full-scale moves, wheel -1
		send_packet(32'hFF7F803F, 4);
		send_packet(32'h08807F07, 4);
		// sync bit clear
		send_packet(32'hF7010208, 4);
		// wheel -8 with top bits of the extra byte set
		send_packet(32'h0C00FFC8, 4);
		drain_results();
	endtask

	task automatic test_scale_limits();
		cfg_write(REG_DPI, 32'd0);
		send_packet(32'h097F8100, 4);
		drain_results();
		cfg_write(REG_DPI, 32'hFFFF_FFFF);
		send_packet(32'h0A807F00, 4);
		drain_results();
		cfg_write(REG_DPI, 32'd1001);
		cfg_write(REG_DPI, 32'd9);
		cfg_write(REG_DPI, 32'd10);
		cfg_write(REG_DPI, 32'd1023);
		cfg_write(REG_DPI, {22'b0, DPI_RESET});
	endtask

	task automatic test_standard_packets();
		cfg_write(REG_MODE, 32'd0);
		send_packet(32'h0B05FB00, 3);
		send_packet(32'h00102000, 3);
		drain_results();
	endtask

	task automatic test_mode_restart();
		// half a packet, then a mode write must restart at the status byte
		send_packet(32'h087F0000, 2);
		drain_results();
		cfg_write(REG_MODE, 32'hFFFF_FFFF);
		send_packet(32'h18010230, 4);
		drain_results();
	endtask

	task automatic test_random_settings();
		logic [31:0] dpi_val;
		logic        mode_val;
		for (int phase = 0; phase < 6; phase++) begin
			mode_val = 1'($urandom_range(0, 1));
			case (phase)
				0: begin
					dpi_val = 32'd10;
					mode_val = 1'b1;
					in_gaps_on = 1'b0;
					stall_on = 1'b0;
				end
				1: begin
					dpi_val = 32'd1000;
					mode_val = 1'b0;
					in_gaps_on = 1'b1;
					stall_on = 1'b1;
				end
				2: begin
					dpi_val = $urandom_range(10, 1000);
					in_gaps_on = 1'b1;
					stall_on = 1'b0;
				end
				3: begin
					dpi_val = $urandom;
					in_gaps_on = 1'b0;
					stall_on = 1'b1;
				end
				4: begin
					dpi_val = $urandom_range(0, 1023);
					in_gaps_on = 1'b1;
					stall_on = 1'b1;
				end
				default: begin
					dpi_val = {22'b0, DPI_RESET};
					mode_val = 1'b1;
					in_gaps_on = 1'b1;
					stall_on = 1'b1;
				end
			endcase
			cfg_write(REG_DPI, dpi_val);
			cfg_write(REG_MODE, {16'($urandom_range(0, 65535)), 15'b0, mode_val});
			repeat (70) send_random_packet();
			drain_results();
		end
	endtask

	task automatic test_backpressure();
		cfg_write(REG_MODE, 32'd1);
		in_gaps_on = 1'b0;
		stall_on = 1'b0;
		hold_request = 1'b1;
		repeat (60) send_random_packet();
		in_gaps_on = 1'b1;
		stall_on = 1'b1;
		drain_results();
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	always @(posedge clk) begin
		if (stall_left == 0) begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap(1'b1);
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		packet_report_t want;
		if (out_valid && !out_stall) begin
			if (predicted_packets.size() == 0) begin
				report_mismatch("packet with none pending", 32'd0, 32'd0);
			end else begin
				want = predicted_packets.pop_front();
				packets_checked++;
				if (packet_ok !== want.ok)
					report_mismatch("packet_ok", 32'(packet_ok), 32'(want.ok));
				if (buttons !== want.buttons)
					report_mismatch("buttons", 32'(buttons), 32'(want.buttons));
				if (move_x !== want.move_x)
					report_mismatch("move_x", 32'($unsigned(move_x)), 32'(want.move_x));
				if (move_y !== want.move_y)
					report_mismatch("move_y", 32'($unsigned(move_y)), 32'(want.move_y));
				if (wheel !== want.wheel)
					report_mismatch("wheel", 32'($unsigned(wheel)), 32'(want.wheel));
				if (good_count !== want.good)
					report_mismatch("good_count", good_count, want.good);
				if (bad_count !== want.bad)
					report_mismatch("bad_count", bad_count, want.bad);
				if (click_count !== want.clicks)
					report_mismatch("click_count", click_count, want.clicks);
				if (wheel_count !== want.wheels)
					report_mismatch("wheel_count", wheel_count, want.wheels);
				if (sum_x !== want.sum_x)
					report_mismatch("sum_x", sum_x, want.sum_x);
				if (sum_y !== want.sum_y)
					report_mismatch("sum_y", sum_y, want.sum_y);
				if (distance !== want.travel)
					report_mismatch("distance", distance, want.travel);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_wheel_packets();
		test_scale_limits();
		test_standard_packets();
		test_mode_restart();
		test_random_settings();
		test_backpressure();
		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes, checked %0d packets (%0d valid, %0d invalid), %0d writes",
			bytes_sent, packets_checked, good_tot, bad_tot, writes_done);
		$display("Ran wheel and standard packets, clamped scales, mode restart, long hold-off");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
